FILE: rtl/lzwd_pkg.sv
// Shared types and constants of the LZ window decompressor.
package lzwd_pkg;

  localparam int unsigned HistDepth = 4096;
  localparam int unsigned HistAw    = $clog2(HistDepth);

  localparam int unsigned SrcW  = 17;
  localparam int unsigned CapW  = 21;
  localparam int unsigned CfgDw = 21;

  // Configuration register indexes
  localparam logic CFG_SOURCE_SIZE   = 1'b0;
  localparam logic CFG_DEST_CAPACITY = 1'b1;

  localparam logic [SrcW-1:0] SRC_SIZE_RST = 17'd2;

  // Error codes; the code field reads zero for non-error results
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_HEADER   = 3'd0;
  localparam logic [2:0] ERR_LITERAL  = 3'd1;
  localparam logic [2:0] ERR_TRUNC    = 3'd2;
  localparam logic [2:0] ERR_DISTANCE = 3'd3;
  localparam logic [2:0] ERR_COPY     = 3'd4;

  localparam logic [4:0] MIN_MATCH = 5'd3;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_DONE = 2'd1,
    KIND_ERR  = 2'd2
  } kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
  } in_t;

  typedef struct packed {
    kind_e           kind;
    logic [2:0]      error_code;
    logic [7:0]      out_byte;
    logic [CapW-1:0] out_total;
    logic            run_last;
  } out_t;

endpackage

FILE: rtl/lzwd_hist_ram.sv
// History window memory: one write port, one registered read port.
module lzwd_hist_ram (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [lzwd_pkg::HistAw-1:0] waddr_i,
  input  logic [7:0]                 wdata_i,
  input  logic                       re_i,
  input  logic [lzwd_pkg::HistAw-1:0] raddr_i,
  output logic [7:0]                 rdata_o
);

  logic [7:0] mem [lzwd_pkg::HistDepth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/lzwd_out_reg.sv
// Output register that holds a result beat until the consumer takes it.
module lzwd_out_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  lzwd_pkg::out_t data_i,
  input  logic           stall_i,
  output logic           free_o,
  output logic           valid_o,
  output lzwd_pkg::out_t data_o
);

  logic           valid_q, valid_d;
  lzwd_pkg::out_t data_q;

  assign free_o  = !valid_q || !stall_i;
  assign valid_d = load_i || (valid_q && stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: rtl/lz_window_decompressor.sv
// Top level of the LZ window decompressor: sequencer, stream state and config registers.
//
// Decodes an LZSS stream with a 4096-byte history, one compressed byte per input beat.
// Each accepted byte is taken in and then decoded; a literal or error then emits one
// result, a back-reference copies 3..18 bytes, each by a history read and then a write
// and emit (the history memory has separate read and write ports), and the last byte
// of an error-free stream is followed by a stream-done result. Output stalls hold the
// sequencer. The input stalls while a byte is being worked on. A result can wait in the
// output register while the next input byte is accepted. History is not cleared: a
// back-reference may only reach bytes written by the current stream, so no clearing pass
// runs after reset. Configuration is always ready and should be written while idle.
module lz_window_decompressor (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  lzwd_pkg::in_t             in_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output lzwd_pkg::out_t            out_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic                      cfg_index_i,
  input  logic [lzwd_pkg::CfgDw-1:0] cfg_data_i
);

  typedef enum logic [5:0] {
    S_WAIT  = 6'b000001,
    S_EVAL  = 6'b000010,
    S_ONE   = 6'b000100,
    S_CP_RD = 6'b001000,
    S_CP_WR = 6'b010000,
    S_FIN   = 6'b100000
  } seq_e;

  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_HDR_LO = 5'b00010,
    PH_HDR_HI = 5'b00100,
    PH_BODY   = 5'b01000,
    PH_TOK_HI = 5'b10000
  } phase_e;

  localparam int unsigned Aw = lzwd_pkg::HistAw;
  localparam int unsigned Cw = lzwd_pkg::CapW;
  localparam int unsigned Sw = lzwd_pkg::SrcW;

  seq_e   state_q, state_d;
  phase_e phase_q, phase_d;

  logic [Sw-1:0] src_size_q;
  logic [Cw-1:0] dest_cap_q;

  logic [Aw-1:0] wr_idx_q, wr_idx_d;
  logic [Cw-1:0] produced_q, produced_d;
  logic [Sw-1:0] consumed_q, consumed_d;
  logic [7:0]    flag_bits_q, flag_bits_d;
  logic [3:0]    flags_left_q, flags_left_d;
  logic [7:0]    held_q, held_d;

  lzwd_pkg::in_t  item_q, item_d;
  lzwd_pkg::out_t one_q, one_d;
  logic           fin_q, fin_d;
  logic [Aw-1:0]  rd_addr_q, rd_addr_d;
  logic [4:0]     copy_left_q, copy_left_d;

  logic           in_accept;
  logic           out_free;
  logic           out_load;
  lzwd_pkg::out_t out_data;

  logic          ram_we;
  logic          ram_re;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;

  // Decode helpers
  logic [Sw-1:0] consumed_n;
  logic          last;
  logic [7:0]    b;
  logic [Aw:0]   back_dist;
  logic [4:0]    count;
  logic [Cw:0]   copy_end;
  logic          err_hit;
  logic [2:0]    err_code;
  logic          lit_hit;
  logic          copy_hit;
  phase_e        phase_nx;

  assign in_stall_o  = (state_q != S_WAIT);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  assign b          = item_q.data_byte;
  assign consumed_n = consumed_q + {{(Sw-1){1'b0}}, 1'b1};
  assign last       = (consumed_n >= src_size_q);
  assign back_dist  = {1'b0, b, held_q[7:4]} + {{Aw{1'b0}}, 1'b1};
  assign count      = {1'b0, held_q[3:0]} + lzwd_pkg::MIN_MATCH;
  assign copy_end   = {1'b0, produced_q} + {{(Cw-4){1'b0}}, count};

  // Decode of one stream byte against the current phase
  always_comb begin
    err_hit  = 1'b0;
    err_code = lzwd_pkg::ERR_NONE;
    lit_hit  = 1'b0;
    copy_hit = 1'b0;
    phase_nx = phase_q;
    unique case (phase_q)
      PH_HDR_LO: begin
        phase_nx = PH_HDR_HI;
      end
      PH_HDR_HI: begin
        if (({1'b0, b, held_q} + 17'd2) != src_size_q) begin
          err_hit  = 1'b1;
          err_code = lzwd_pkg::ERR_HEADER;
        end else begin
          phase_nx = PH_BODY;
        end
      end
      PH_BODY: begin
        if (flags_left_q != 4'd0) begin
          if (flag_bits_q[7]) begin
            if (produced_q >= dest_cap_q) begin
              err_hit  = 1'b1;
              err_code = lzwd_pkg::ERR_LITERAL;
            end else begin
              lit_hit = 1'b1;
            end
          end else if (last) begin
            err_hit  = 1'b1;
            err_code = lzwd_pkg::ERR_TRUNC;
          end else begin
            phase_nx = PH_TOK_HI;
          end
        end
      end
      PH_TOK_HI: begin
        phase_nx = PH_BODY;
        if ({{(Cw-Aw-1){1'b0}}, back_dist} > produced_q) begin
          err_hit  = 1'b1;
          err_code = lzwd_pkg::ERR_DISTANCE;
        end else if (copy_end > {1'b0, dest_cap_q}) begin
          err_hit  = 1'b1;
          err_code = lzwd_pkg::ERR_COPY;
        end else begin
          copy_hit = 1'b1;
        end
      end
      default: begin
        phase_nx = PH_IDLE;
      end
    endcase
    if (err_hit) begin
      phase_nx = PH_IDLE;
    end
  end

  // Sequencer
  always_comb begin
    state_d      = state_q;
    phase_d      = phase_q;
    wr_idx_d     = wr_idx_q;
    produced_d   = produced_q;
    consumed_d   = consumed_q;
    flag_bits_d  = flag_bits_q;
    flags_left_d = flags_left_q;
    held_d       = held_q;
    item_d       = item_q;
    one_d        = one_q;
    fin_d        = fin_q;
    rd_addr_d    = rd_addr_q;
    copy_left_d  = copy_left_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_wdata    = ram_rdata;
    out_load     = 1'b0;
    out_data     = one_q;

    unique case (state_q)
      S_WAIT: begin
        if (in_accept) begin
          item_d  = in_i;
          state_d = S_EVAL;
          if (in_i.first_byte) begin
            wr_idx_d     = '0;
            produced_d   = '0;
            consumed_d   = '0;
            flag_bits_d  = '0;
            flags_left_d = '0;
            held_d       = '0;
            phase_d      = PH_HDR_LO;
          end
        end
      end
      S_EVAL: begin
        state_d = S_WAIT;
        fin_d   = 1'b0;
        if (phase_q != PH_IDLE) begin
          consumed_d = consumed_n;
          phase_d    = phase_nx;
          unique case (phase_q)
            PH_HDR_LO: held_d = b;
            PH_BODY: begin
              if (flags_left_q == 4'd0) begin
                flag_bits_d  = b;
                flags_left_d = 4'd8;
              end else begin
                flag_bits_d  = {flag_bits_q[6:0], 1'b0};
                flags_left_d = flags_left_q - 4'd1;
                held_d       = b;
              end
            end
            default: begin
            end
          endcase
          fin_d = (phase_nx != PH_IDLE) && last;
          if (fin_d) begin
            phase_d = PH_IDLE;
          end
          one_d.kind       = err_hit ? lzwd_pkg::KIND_ERR : lzwd_pkg::KIND_BYTE;
          one_d.error_code = err_code;
          one_d.out_byte   = err_hit ? 8'd0 : b;
          one_d.out_total  = produced_q;
          one_d.run_last   = 1'b1;
          rd_addr_d        = wr_idx_q - back_dist[Aw-1:0];
          copy_left_d      = count;
          priority if (err_hit || lit_hit) begin
            state_d = S_ONE;
          end else if (copy_hit) begin
            state_d = S_CP_RD;
          end else if (fin_d) begin
            state_d = S_FIN;
          end else begin
            state_d = S_WAIT;
          end
        end
      end
      S_ONE: begin
        if (out_free) begin
          out_load          = 1'b1;
          out_data          = one_q;
          out_data.run_last = !fin_q;
          if (one_q.kind == lzwd_pkg::KIND_BYTE) begin
            ram_we             = 1'b1;
            ram_wdata          = one_q.out_byte;
            wr_idx_d           = wr_idx_q + {{(Aw-1){1'b0}}, 1'b1};
            produced_d         = produced_q + {{(Cw-1){1'b0}}, 1'b1};
            out_data.out_total = produced_d;
          end
          state_d = fin_q ? S_FIN : S_WAIT;
        end
      end
      S_CP_RD: begin
        ram_re    = 1'b1;
        rd_addr_d = rd_addr_q + {{(Aw-1){1'b0}}, 1'b1};
        state_d   = S_CP_WR;
      end
      S_CP_WR: begin
        if (out_free) begin
          ram_we              = 1'b1;
          ram_wdata           = ram_rdata;
          wr_idx_d            = wr_idx_q + {{(Aw-1){1'b0}}, 1'b1};
          produced_d          = produced_q + {{(Cw-1){1'b0}}, 1'b1};
          copy_left_d         = copy_left_q - 5'd1;
          out_load            = 1'b1;
          out_data.kind       = lzwd_pkg::KIND_BYTE;
          out_data.error_code = lzwd_pkg::ERR_NONE;
          out_data.out_byte   = ram_rdata;
          out_data.out_total  = produced_d;
          out_data.run_last   = (copy_left_q == 5'd1) && !fin_q;
          if (copy_left_q == 5'd1) begin
            state_d = fin_q ? S_FIN : S_WAIT;
          end else begin
            state_d = S_CP_RD;
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_load            = 1'b1;
          out_data.kind       = lzwd_pkg::KIND_DONE;
          out_data.error_code = lzwd_pkg::ERR_NONE;
          out_data.out_byte   = 8'd0;
          out_data.out_total  = produced_q;
          out_data.run_last   = 1'b1;
          state_d             = S_WAIT;
        end
      end
      default: begin
        state_d = S_WAIT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_WAIT;
      phase_q      <= PH_IDLE;
      wr_idx_q     <= '0;
      produced_q   <= '0;
      consumed_q   <= '0;
      flag_bits_q  <= '0;
      flags_left_q <= '0;
      held_q       <= '0;
      fin_q        <= 1'b0;
      copy_left_q  <= '0;
      src_size_q   <= lzwd_pkg::SRC_SIZE_RST;
      dest_cap_q   <= '0;
    end else begin
      state_q      <= state_d;
      phase_q      <= phase_d;
      wr_idx_q     <= wr_idx_d;
      produced_q   <= produced_d;
      consumed_q   <= consumed_d;
      flag_bits_q  <= flag_bits_d;
      flags_left_q <= flags_left_d;
      held_q       <= held_d;
      fin_q        <= fin_d;
      copy_left_q  <= copy_left_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == lzwd_pkg::CFG_SOURCE_SIZE) begin
          src_size_q <= cfg_data_i[Sw-1:0];
        end else if (cfg_index_i == lzwd_pkg::CFG_DEST_CAPACITY) begin
          dest_cap_q <= cfg_data_i;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    item_q    <= item_d;
    one_q     <= one_d;
    rd_addr_q <= rd_addr_d;
  end

  lzwd_hist_ram u_hist (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_idx_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rd_addr_q),
    .rdata_o (ram_rdata)
  );

  lzwd_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (out_load),
    .data_i  (out_data),
    .stall_i (out_stall_i),
    .free_o  (out_free),
    .valid_o (out_valid_o),
    .data_o  (out_o)
  );

endmodule
